### hw/rtl/fbip_pkg.sv
// Shared types, constants and helpers for the file block to indirect path mapper.
// No dependencies; every other file in hw/rtl uses it by scoped names.
package fbip_pkg;

   localparam int BLK_W  = 32;            // logical block number width
   localparam int MAG_W  = BLK_W - 1;     // non-negative magnitude width
   localparam int OFF_W  = 14;            // offset field width
   localparam int DEP_W  = 3;             // path depth width
   localparam int K_W    = 4;             // pointer_bits_log2 width
   localparam int SH_W   = 6;             // shift amounts up to 3*K_MAX
   localparam int ADDR_W = 44;            // room for the triple indirect reach

   localparam logic [K_W-1:0] K_MIN = 4'd8;
   localparam logic [K_W-1:0] K_MAX = 4'd14;

   localparam logic [DEP_W-1:0] DEPTH_NONE   = 3'd0;
   localparam logic [DEP_W-1:0] DEPTH_DIRECT = 3'd1;
   localparam logic [DEP_W-1:0] DEPTH_SINGLE = 3'd2;
   localparam logic [DEP_W-1:0] DEPTH_DOUBLE = 3'd3;
   localparam logic [DEP_W-1:0] DEPTH_TRIPLE = 3'd4;

   typedef enum logic [1:0] {
      ST_MAPPED   = 2'd0,
      ST_NEGATIVE = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CLS_DIRECT,
      CLS_SINGLE,
      CLS_DOUBLE,
      CLS_TRIPLE,
      CLS_NEG,
      CLS_FAR
   } cls_type;

   // Payload between the classify stage and the offset extraction stages.
   typedef struct packed {
      cls_type          cls;
      logic [K_W-1:0]   kbits;
      logic [MAG_W-1:0] blk;
   } cls_pkt_type;

   // Clamp the register value into the supported range.
   function automatic logic [K_W-1:0] eff_bits(input logic [K_W-1:0] raw);
      logic [K_W-1:0] k;
      k = raw;
      if (k < K_MIN) k = K_MIN;
      if (k > K_MAX) k = K_MAX;
      return k;
   endfunction

   function automatic logic [ADDR_W-1:0] pow2(input logic [SH_W-1:0] e);
      return ADDR_W'(1) << e;
   endfunction

   // First block number of the single (1), double (2), triple (3) indirect
   // ranges and end of reach (4). The powers of two occupy disjoint bits above
   // the direct count, so the running sums are plain ORs.
   function automatic logic [ADDR_W-1:0] level_base(input logic [K_W-1:0] k,
                                                    input int direct,
                                                    input int lvl);
      logic [SH_W-1:0]   k1;
      logic [ADDR_W-1:0] acc;
      k1  = SH_W'(k);
      acc = ADDR_W'(direct);
      if (lvl >= 2) acc = acc | pow2(k1);
      if (lvl >= 3) acc = acc | pow2(SH_W'(k1 << 1));
      if (lvl >= 4) acc = acc | pow2(SH_W'(k1 + SH_W'(k1 << 1)));
      return acc;
   endfunction

endpackage

### hw/rtl/fbip_classify.sv
// Classify stage: compares the block number against the range limits.
// Depends on fbip_pkg.
module fbip_classify #(
   parameter int DIRECT_SLOTS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [fbip_pkg::BLK_W-1:0]  in_block,
   input  logic [fbip_pkg::K_W-1:0]    in_kbits,
   output logic                        out_valid,
   output fbip_pkg::cls_pkt_type       out_pkt
);

   logic                      valid_ff;
   fbip_pkg::cls_pkt_type     pkt_ff;
   fbip_pkg::cls_pkt_type     pkt_in;
   logic [fbip_pkg::ADDR_W-1:0] blk_ext;

   always_comb begin
      blk_ext      = fbip_pkg::ADDR_W'(in_block[fbip_pkg::MAG_W-1:0]);
      pkt_in.blk   = in_block[fbip_pkg::MAG_W-1:0];
      pkt_in.kbits = in_kbits;
      priority if (in_block[fbip_pkg::BLK_W-1]) begin
         pkt_in.cls = fbip_pkg::CLS_NEG;
      end else if (blk_ext < fbip_pkg::level_base(in_kbits, DIRECT_SLOTS, 1)) begin
         pkt_in.cls = fbip_pkg::CLS_DIRECT;
      end else if (blk_ext < fbip_pkg::level_base(in_kbits, DIRECT_SLOTS, 2)) begin
         pkt_in.cls = fbip_pkg::CLS_SINGLE;
      end else if (blk_ext < fbip_pkg::level_base(in_kbits, DIRECT_SLOTS, 3)) begin
         pkt_in.cls = fbip_pkg::CLS_DOUBLE;
      end else if (blk_ext < fbip_pkg::level_base(in_kbits, DIRECT_SLOTS, 4)) begin
         pkt_in.cls = fbip_pkg::CLS_TRIPLE;
      end else begin
         pkt_in.cls = fbip_pkg::CLS_FAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      pkt_ff <= pkt_in;
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;

endmodule

### hw/rtl/fbip_extract.sv
// Residual subtract stage followed by the offset / boundary extraction stage.
// Depends on fbip_pkg.
module fbip_extract #(
   parameter int DIRECT_SLOTS = 12,
   parameter int SINGLE_SLOT  = 12,
   parameter int DOUBLE_SLOT  = 13,
   parameter int TRIPLE_SLOT  = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  fbip_pkg::cls_pkt_type         in_pkt,
   output logic                          out_valid,
   output logic [fbip_pkg::DEP_W-1:0]    out_depth,
   output logic [fbip_pkg::OFF_W-1:0]    out_off0,
   output logic [fbip_pkg::OFF_W-1:0]    out_off1,
   output logic [fbip_pkg::OFF_W-1:0]    out_off2,
   output logic [fbip_pkg::OFF_W-1:0]    out_off3,
   output logic                          out_bnd,
   output logic [1:0]                    out_status
);

   // residual stage
   logic                          rv_ff;
   fbip_pkg::cls_pkt_type         rpkt_ff;
   fbip_pkg::cls_pkt_type         rpkt_in;
   logic [fbip_pkg::ADDR_W-1:0]   base;
   logic [fbip_pkg::ADDR_W-1:0]   diff;

   always_comb begin
      unique case (in_pkt.cls)
         fbip_pkg::CLS_SINGLE: base = fbip_pkg::level_base(in_pkt.kbits, DIRECT_SLOTS, 1);
         fbip_pkg::CLS_DOUBLE: base = fbip_pkg::level_base(in_pkt.kbits, DIRECT_SLOTS, 2);
         fbip_pkg::CLS_TRIPLE: base = fbip_pkg::level_base(in_pkt.kbits, DIRECT_SLOTS, 3);
         default:              base = '0;
      endcase
      diff          = fbip_pkg::ADDR_W'(in_pkt.blk) - base;
      rpkt_in.cls   = in_pkt.cls;
      rpkt_in.kbits = in_pkt.kbits;
      rpkt_in.blk   = diff[fbip_pkg::MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= in_valid;
      end
      rpkt_ff <= rpkt_in;
   end

   // extraction stage
   logic                         ov_ff;
   logic [fbip_pkg::DEP_W-1:0]   depth_ff, depth_in;
   logic [fbip_pkg::OFF_W-1:0]   off0_ff, off0_in;
   logic [fbip_pkg::OFF_W-1:0]   off1_ff, off1_in;
   logic [fbip_pkg::OFF_W-1:0]   off2_ff, off2_in;
   logic [fbip_pkg::OFF_W-1:0]   off3_ff, off3_in;
   logic                         bnd_ff, bnd_in;
   fbip_pkg::status_type         status_ff, status_in;

   logic [fbip_pkg::OFF_W-1:0]   mask;
   logic [fbip_pkg::MAG_W-1:0]   sh1;
   logic [fbip_pkg::MAG_W-1:0]   sh2;
   logic [fbip_pkg::OFF_W-1:0]   low;
   logic [fbip_pkg::SH_W-1:0]    k1;

   always_comb begin
      k1   = fbip_pkg::SH_W'(rpkt_ff.kbits);
      mask = ~({fbip_pkg::OFF_W{1'b1}} << rpkt_ff.kbits);
      sh1  = rpkt_ff.blk >> k1;
      sh2  = rpkt_ff.blk >> fbip_pkg::SH_W'(k1 << 1);
      low  = rpkt_ff.blk[fbip_pkg::OFF_W-1:0] & mask;

      depth_in  = fbip_pkg::DEPTH_NONE;
      off0_in   = '0;
      off1_in   = '0;
      off2_in   = '0;
      off3_in   = '0;
      bnd_in    = 1'b0;
      status_in = fbip_pkg::ST_MAPPED;
      unique case (rpkt_ff.cls)
         fbip_pkg::CLS_DIRECT: begin
            depth_in = fbip_pkg::DEPTH_DIRECT;
            off0_in  = rpkt_ff.blk[fbip_pkg::OFF_W-1:0];
            bnd_in   = (low == fbip_pkg::OFF_W'(DIRECT_SLOTS - 1));
         end
         fbip_pkg::CLS_SINGLE: begin
            depth_in = fbip_pkg::DEPTH_SINGLE;
            off0_in  = fbip_pkg::OFF_W'(SINGLE_SLOT);
            off1_in  = rpkt_ff.blk[fbip_pkg::OFF_W-1:0];
            bnd_in   = (low == mask);
         end
         fbip_pkg::CLS_DOUBLE: begin
            depth_in = fbip_pkg::DEPTH_DOUBLE;
            off0_in  = fbip_pkg::OFF_W'(DOUBLE_SLOT);
            off1_in  = sh1[fbip_pkg::OFF_W-1:0];
            off2_in  = low;
            bnd_in   = (low == mask);
         end
         fbip_pkg::CLS_TRIPLE: begin
            depth_in = fbip_pkg::DEPTH_TRIPLE;
            off0_in  = fbip_pkg::OFF_W'(TRIPLE_SLOT);
            off1_in  = sh2[fbip_pkg::OFF_W-1:0];
            off2_in  = sh1[fbip_pkg::OFF_W-1:0] & mask;
            off3_in  = low;
            bnd_in   = (low == mask);
         end
         fbip_pkg::CLS_NEG: begin
            status_in = fbip_pkg::ST_NEGATIVE;
         end
         fbip_pkg::CLS_FAR: begin
            status_in = fbip_pkg::ST_RANGE;
         end
         default: begin
            status_in = fbip_pkg::ST_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= rv_ff;
      end
      depth_ff  <= depth_in;
      off0_ff   <= off0_in;
      off1_ff   <= off1_in;
      off2_ff   <= off2_in;
      off3_ff   <= off3_in;
      bnd_ff    <= bnd_in;
      status_ff <= status_in;
   end

   assign out_valid  = ov_ff;
   assign out_depth  = depth_ff;
   assign out_off0   = off0_ff;
   assign out_off1   = off1_ff;
   assign out_off2   = off2_ff;
   assign out_off3   = off3_ff;
   assign out_bnd    = bnd_ff;
   assign out_status = status_ff;

endmodule

### hw/rtl/file_block_to_indirect_path.sv
// File block to indirect path mapper: top level, config register and input stage.
// Depends on fbip_pkg, fbip_classify and fbip_extract.
//
// Maps a signed logical block number onto the direct / single / double /
// triple indirect path of a Unix style inode. One request is taken every clock
// (busy never rises); rsp_valid pulses for one cycle three clocks after the
// edge that took start, and the result must be captured at the edge that ends
// that cycle since the receiver cannot stall. The four stages are input
// capture, range compare, residual subtract, and the offset shifter with
// output registers.
// csr_wdata sets log2 of pointers per block (clamped to 8..14); write it only
// while no request is in flight.
module file_block_to_indirect_path #(
   parameter int DIRECT_SLOTS = 12,
   parameter int SINGLE_SLOT  = 12,
   parameter int DOUBLE_SLOT  = 13,
   parameter int TRIPLE_SLOT  = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [31:0]          req_logical_block,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_path_depth,
   output logic [13:0]                 rsp_slot_offset,
   output logic [13:0]                 rsp_level1_offset,
   output logic [13:0]                 rsp_level2_offset,
   output logic [13:0]                 rsp_level3_offset,
   output logic                        rsp_at_boundary,
   output logic [1:0]                  rsp_map_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [3:0]                  csr_wdata
);

   logic [fbip_pkg::K_W-1:0]   kreg_ff;
   logic [fbip_pkg::K_W-1:0]   kreg_in;
   logic                       iv_ff;
   logic [fbip_pkg::BLK_W-1:0] blk_ff;
   logic [fbip_pkg::K_W-1:0]   keff_ff;

   logic                       cv;
   fbip_pkg::cls_pkt_type      cpkt;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign kreg_in   = (csr_valid && csr_ready) ? csr_wdata : kreg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kreg_ff <= fbip_pkg::K_MIN;
         iv_ff   <= 1'b0;
      end else begin
         kreg_ff <= kreg_in;
         iv_ff   <= start && !busy;
      end
      blk_ff  <= req_logical_block;
      keff_ff <= fbip_pkg::eff_bits(kreg_ff);
   end

   fbip_classify #(
      .DIRECT_SLOTS (DIRECT_SLOTS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (iv_ff),
      .in_block  (blk_ff),
      .in_kbits  (keff_ff),
      .out_valid (cv),
      .out_pkt   (cpkt)
   );

   fbip_extract #(
      .DIRECT_SLOTS (DIRECT_SLOTS),
      .SINGLE_SLOT  (SINGLE_SLOT),
      .DOUBLE_SLOT  (DOUBLE_SLOT),
      .TRIPLE_SLOT  (TRIPLE_SLOT)
   ) u_extract (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (cv),
      .in_pkt     (cpkt),
      .out_valid  (rsp_valid),
      .out_depth  (rsp_path_depth),
      .out_off0   (rsp_slot_offset),
      .out_off1   (rsp_level1_offset),
      .out_off2   (rsp_level2_offset),
      .out_off3   (rsp_level3_offset),
      .out_bnd    (rsp_at_boundary),
      .out_status (rsp_map_status)
   );

endmodule

### dv/tb_file_block_to_indirect_path.sv
// Self-checking testbench for file_block_to_indirect_path: a directed table of block
// numbers and pointer-block sizes, then random phases, each checked against a local mapper.
// Depends on fbip_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_file_block_to_indirect_path;

   localparam int N_DIRECT    = 12;
   localparam logic [13:0] SLOT_SINGLE = 14'd12;
   localparam logic [13:0] SLOT_DOUBLE = 14'd13;
   localparam logic [13:0] SLOT_TRIPLE = 14'd14;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int LATENCY_PAD = 6;

   typedef struct packed {
      logic [2:0]           depth;
      logic [13:0]          slot;
      logic [13:0]          l1;
      logic [13:0]          l2;
      logic [13:0]          l3;
      logic                 bnd;
      fbip_pkg::status_type status;
   } path_map_type;

   typedef struct {
      bit           is_cfg;
      logic [3:0]   cfg;
      logic [31:0]  blk;
      bit           typed;
      path_map_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_logical_block;
   logic               rsp_valid;
   logic [2:0]         rsp_path_depth;
   logic [13:0]        rsp_slot_offset;
   logic [13:0]        rsp_level1_offset;
   logic [13:0]        rsp_level2_offset;
   logic [13:0]        rsp_level3_offset;
   logic               rsp_at_boundary;
   logic [1:0]         rsp_map_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_wdata;

   path_map_type pending_paths[$];
   stim_row_type stim_rows[$];
   logic [3:0] ptr_bits;
   int         errors;
   int         results_checked;
   int         depth_hits[0:4];
   int         neg_hits;
   int         far_hits;
   int         bnd_hits;
   int         cfg_writes;

   file_block_to_indirect_path #(
      .DIRECT_SLOTS (N_DIRECT),
      .SINGLE_SLOT  (SLOT_SINGLE),
      .DOUBLE_SLOT  (SLOT_DOUBLE),
      .TRIPLE_SLOT  (SLOT_TRIPLE)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_logical_block (req_logical_block),
      .rsp_valid         (rsp_valid),
      .rsp_path_depth    (rsp_path_depth),
      .rsp_slot_offset   (rsp_slot_offset),
      .rsp_level1_offset (rsp_level1_offset),
      .rsp_level2_offset (rsp_level2_offset),
      .rsp_level3_offset (rsp_level3_offset),
      .rsp_at_boundary   (rsp_at_boundary),
      .rsp_map_status    (rsp_map_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("** file_block_to_indirect_path: FAILED **");
      $finish;
   end

   function automatic int unsigned clamp_bits(input logic [3:0] raw);
      if (raw < 4'd8) return 8;
      if (raw > 4'd14) return 14;
      return raw;
   endfunction

   // Walk the direct / single / double / triple ranges, peeling each off in turn.
   function automatic path_map_type map_block(input logic [31:0] blk,
                                              input logic [3:0] raw_bits);
      int unsigned       k;
      longint unsigned   ptrs, mask, dbl, b;
      path_map_type      r;
      k    = clamp_bits(raw_bits);
      ptrs = 64'd1 << k;
      mask = ptrs - 1;
      dbl  = 64'd1 << (2 * k);
      r        = '0;
      r.status = fbip_pkg::ST_MAPPED;
      if (blk[31]) begin
         r.status = fbip_pkg::ST_NEGATIVE;
      end else begin
         b = blk;
         if (b < N_DIRECT) begin
            r.depth = fbip_pkg::DEPTH_DIRECT;
            r.slot  = b[13:0];
            r.bnd   = ((b & mask) == N_DIRECT - 1);
         end else begin
            b -= N_DIRECT;
            if (b < ptrs) begin
               r.depth = fbip_pkg::DEPTH_SINGLE;
               r.slot  = SLOT_SINGLE;
               r.l1    = b[13:0];
            end else begin
               b -= ptrs;
               if (b < dbl) begin
                  r.depth = fbip_pkg::DEPTH_DOUBLE;
                  r.slot  = SLOT_DOUBLE;
                  r.l1    = 14'(b >> k);
                  r.l2    = 14'(b & mask);
               end else begin
                  b -= dbl;
                  if ((b >> (2 * k)) < ptrs) begin
                     r.depth = fbip_pkg::DEPTH_TRIPLE;
                     r.slot  = SLOT_TRIPLE;
                     r.l1    = 14'(b >> (2 * k));
                     r.l2    = 14'((b >> k) & mask);
                     r.l3    = 14'(b & mask);
                  end else begin
                     r.status = fbip_pkg::ST_RANGE;
                  end
               end
            end
            // boundary looks at what is left after the last subtraction
            if (r.depth != fbip_pkg::DEPTH_NONE) r.bnd = ((b & mask) == mask);
         end
      end
      return r;
   endfunction

   // Random block number biased toward range starts, ends and each depth.
   function automatic logic [31:0] pick_block(input logic [3:0] raw_bits);
      int unsigned     k;
      longint unsigned base1, base2, base3, reach, lvl_start, v, r64;
      k     = clamp_bits(raw_bits);
      base1 = N_DIRECT;
      base2 = base1 + (64'd1 << k);
      base3 = base2 + (64'd1 << (2 * k));
      reach = base3 + (64'd1 << (3 * k));
      r64   = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return {1'b1, 31'($urandom)};
         2: v = $urandom_range(0, N_DIRECT - 1);
         3: v = base1 + (r64 & ((64'd1 << k) - 1));
         4: v = base2 + (r64 % (64'd1 << (2 * k)));
         5: v = base3 + (r64 % (reach - base3));
         6: begin
            case ($urandom_range(0, 3))
               0: lvl_start = base1;
               1: lvl_start = base2;
               2: lvl_start = base3;
               default: lvl_start = reach;
            endcase
            v = lvl_start + $urandom_range(0, 3) - 2;
         end
         7: v = ($urandom & 32'h7FFF_FFFF) | ((64'd1 << k) - 1);
         default: v = $urandom & 32'h7FFF_FFFF;
      endcase
      if (v > 64'h7FFF_FFFF) v = {1'b0, 31'($urandom)};
      return v[31:0];
   endfunction

   task automatic add_cfg(input logic [3:0] v);
      stim_row_type row;
      row        = '{default: '0};
      row.is_cfg = 1'b1;
      row.cfg    = v;
      stim_rows.push_back(row);
   endtask

   task automatic add_item(input logic [31:0] blk);
      stim_row_type row;
      row     = '{default: '0};
      row.blk = blk;
      stim_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [31:0] blk, input logic [2:0] depth,
                            input logic [13:0] slot, input logic [13:0] l1,
                            input logic [13:0] l2, input logic [13:0] l3,
                            input logic bnd, input fbip_pkg::status_type status);
      stim_row_type row;
      row       = '{default: '0};
      row.blk   = blk;
      row.typed = 1'b1;
      row.want  = '{depth, slot, l1, l2, l3, bnd, status};
      stim_rows.push_back(row);
   endtask

   task automatic send_block(input logic [31:0] blk, input bit typed,
                             input path_map_type want);
      start             <= 1'b1;
      req_logical_block <= blk;
      do @(posedge clock); while (busy);
      pending_paths.push_back(typed ? want : map_block(blk, ptr_bits));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_paths.size() != 0) @(posedge clock);
   endtask

   task automatic write_ptr_bits(input logic [3:0] v);
      drain();
      repeat (LATENCY_PAD) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ptr_bits = v;
      cfg_writes++;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_paths
      path_map_type want;
      if (!reset && rsp_valid) begin
         if (pending_paths.size() == 0) begin
            $display("%0t: unexpected result, depth %0d status %0d", $time,
                     rsp_path_depth, rsp_map_status);
            errors++;
         end else begin
            want = pending_paths.pop_front();
            check_field("path_depth", want.depth, rsp_path_depth);
            check_field("slot_offset", want.slot, rsp_slot_offset);
            check_field("level1_offset", want.l1, rsp_level1_offset);
            check_field("level2_offset", want.l2, rsp_level2_offset);
            check_field("level3_offset", want.l3, rsp_level3_offset);
            check_field("at_boundary", want.bnd, rsp_at_boundary);
            check_field("map_status", want.status, rsp_map_status);
            results_checked++;
            bnd_hits += want.bnd;
            case (want.status)
               fbip_pkg::ST_NEGATIVE: neg_hits++;
               fbip_pkg::ST_RANGE:    far_hits++;
               default:               depth_hits[want.depth]++;
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [3:0]  phase_cfg[11];
      int unsigned burst;
      int unsigned idle_pct;
      int          waited;
      phase_cfg = '{4'd8, 4'd14, 4'd15, 4'd0, 4'd10, 4'd9, 4'd11, 4'd12, 4'd13, 4'd7, 4'd3};
      reset             = 1'b1;
      start             = 1'b0;
      req_logical_block = '0;
      csr_valid         = 1'b0;
      csr_wdata         = '0;
      ptr_bits          = 4'd8;
      errors            = 0;
      results_checked   = 0;
      depth_hits        = '{default: 0};
      neg_hits          = 0;
      far_hits          = 0;
      bnd_hits          = 0;
      cfg_writes        = 0;
      burst             = 0;

      // 256 pointers per block after reset: ranges start at 12, 268, 65804, 16843020
      add_typed(32'd0, fbip_pkg::DEPTH_DIRECT, 0, 0, 0, 0, 1'b0, fbip_pkg::ST_MAPPED);
      add_typed(32'd11, fbip_pkg::DEPTH_DIRECT, 11, 0, 0, 0, 1'b1, fbip_pkg::ST_MAPPED);
      add_typed(32'd12, fbip_pkg::DEPTH_SINGLE, SLOT_SINGLE, 0, 0, 0, 1'b0,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd267, fbip_pkg::DEPTH_SINGLE, SLOT_SINGLE, 255, 0, 0, 1'b1,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd268, fbip_pkg::DEPTH_DOUBLE, SLOT_DOUBLE, 0, 0, 0, 1'b0,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd65803, fbip_pkg::DEPTH_DOUBLE, SLOT_DOUBLE, 255, 255, 0, 1'b1,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd65804, fbip_pkg::DEPTH_TRIPLE, SLOT_TRIPLE, 0, 0, 0, 1'b0,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd16843019, fbip_pkg::DEPTH_TRIPLE, SLOT_TRIPLE, 255, 255, 255, 1'b1,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd16843020, fbip_pkg::DEPTH_NONE, 0, 0, 0, 0, 1'b0, fbip_pkg::ST_RANGE);
      add_typed(32'h7FFF_FFFF, fbip_pkg::DEPTH_NONE, 0, 0, 0, 0, 1'b0, fbip_pkg::ST_RANGE);
      add_typed(32'hFFFF_FFFF, fbip_pkg::DEPTH_NONE, 0, 0, 0, 0, 1'b0,
                fbip_pkg::ST_NEGATIVE);
      add_typed(32'h8000_0000, fbip_pkg::DEPTH_NONE, 0, 0, 0, 0, 1'b0,
                fbip_pkg::ST_NEGATIVE);
      add_item(32'd5);
      add_item(32'd1000);
      add_item(32'd70000);
      // above the legal range, treated as 14
      add_cfg(4'd15);
      add_item(32'h7FFF_FFFF);
      add_item(32'd16395);
      add_item(32'd16396);
      add_item(32'd268451852);
      add_cfg(4'd10);
      add_typed(32'd1074791435, fbip_pkg::DEPTH_TRIPLE, SLOT_TRIPLE, 1023, 1023, 1023, 1'b1,
                fbip_pkg::ST_MAPPED);
      add_typed(32'd1074791436, fbip_pkg::DEPTH_NONE, 0, 0, 0, 0, 1'b0, fbip_pkg::ST_RANGE);
      // below the legal range, treated as 8
      add_cfg(4'd0);
      add_typed(32'd11, fbip_pkg::DEPTH_DIRECT, 11, 0, 0, 0, 1'b1, fbip_pkg::ST_MAPPED);
      add_item(32'h5555_5555);
      add_item(32'h2AAA_AAAA);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg) write_ptr_bits(stim_rows[i].cfg);
         else send_block(stim_rows[i].blk, stim_rows[i].typed, stim_rows[i].want);
      end

      foreach (phase_cfg[p]) begin
         write_ptr_bits(phase_cfg[p]);
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 87;
            default: idle_pct = 24;
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 2 && n == ITEMS_PER_PHASE / 2) drain();
            send_block(pick_block(ptr_bits), 1'b0, '0);
            if (burst != 0) begin
               burst--;
            end else if ($urandom_range(0, 31) == 0) begin
               burst = $urandom_range(8, 24);
            end else if ($urandom_range(0, 99) < idle_pct) begin
               // each further cycle stays idle with the same odds
               start <= 1'b0;
               do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
            end
         end
      end

      start  <= 1'b0;
      waited = 0;
      while (pending_paths.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_PAD) @(posedge clock);
      if (pending_paths.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_paths.size());
         errors++;
      end

      $display("checked %0d results over %0d register writes: direct %0d single %0d",
               results_checked, cfg_writes, depth_hits[1], depth_hits[2]);
      $display("double %0d triple %0d, negative %0d, beyond reach %0d, boundary %0d",
               depth_hits[3], depth_hits[4], neg_hits, far_hits, bnd_hits);
      if (errors == 0) begin
         $display("** file_block_to_indirect_path: PASSED **");
      end else begin
         $display("** file_block_to_indirect_path: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/fbip_pkg.sv
hw/rtl/fbip_classify.sv
hw/rtl/fbip_extract.sv
hw/rtl/file_block_to_indirect_path.sv
dv/tb_file_block_to_indirect_path.sv
